// ===== design/lzrd_pkg.sv =====
// lzrd_pkg: shared constants and types for the lzss ring decoder
// depends on nothing; imported by lzss_ring_decoder, lzrd_stream_checker and the testbench
`timescale 1ns / 1ps

package lzrd_pkg;

  localparam int RING_DEPTH = 4096;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int FILL_W     = RING_AW + 1;
  localparam int MATCH_MAX  = 18;
  localparam int MATCH_BIAS = 2;
  localparam int CNT_W      = $clog2(MATCH_MAX + 1);

  // first write position after reset; entries below it start as spaces
  localparam logic [RING_AW-1:0] RESET_POS  = RING_AW'(RING_DEPTH - MATCH_MAX);
  localparam logic [7:0]         SPACE_CHAR = 8'h20;
  localparam logic [7:0]         ZERO_CHAR  = 8'h00;

  typedef enum logic [1:0] {
    PH_FLAG  = 2'd0,
    PH_TOKEN = 2'd1,
    PH_MHIGH = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_PUT  = 2'd2
  } state_e;

endpackage

// ===== design/lzss_ring_decoder.sv =====
// lzss_ring_decoder: byte-serial lzss decompressor with a 4096-byte history ring
// depends on lzrd_pkg for constants, phase and sequencer types
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid_i / in_stall_o / in_byte_i) takes one compressed
// byte per transaction: flag bytes, literals and two-byte match references.
// The output channel (out_valid_o / out_stall_i / out_byte_o / out_last_o)
// delivers decoded bytes; out_last_o marks the final byte caused by one input.
// Flag and first match bytes are absorbed in the idle state and give no output.
// A literal is accepted in the idle state and then written to the ring and the
// output register in the put state. A second match byte starts a copy of 3 to
// 18 bytes; each copied byte passes the single ring port as a registered read,
// then as a write back with output, and the input is stalled meanwhile.
// The output register lets a new input be accepted while a result still waits.
// When out_stall_i holds the output register full, the sequencer waits in
// place; nothing is lost or repeated.
// Reset returns the write position to 4078 and empties the flag state. The
// ring needs no clearing pass: a fill count tracks the entries written since
// reset, and unwritten entries read as spaces below 4078 and zeros above.
module lzss_ring_decoder
  import lzrd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  state_e               state_q, state_d;
  phase_e               phase_q, phase_d;
  logic [15:0]          flag_q, flag_d;
  logic [7:0]           mlow_q, mlow_d;
  logic [7:0]           cur_q, cur_d;
  logic                 copy_q, copy_d;
  logic [RING_AW-1:0]   wp_q, wp_d;
  logic [RING_AW-1:0]   rd_pos_q, rd_pos_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic                 rd_hit_q, rd_hit_d;
  logic [7:0]           rd_dflt_q, rd_dflt_d;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_byte_q, out_byte_d;
  logic                 out_last_q, out_last_d;

  logic [7:0]           ring_mem [RING_DEPTH];
  logic [7:0]           rd_data_q;
  logic                 mem_we, mem_re;
  logic [7:0]           put_byte;
  logic [7:0]           rd_byte;
  logic [RING_AW-1:0]   rd_ofs;
  logic                 slot_free;
  logic                 put_last;
  logic [15:0]          flag_next;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  // entries written since reset form one run starting at the reset position
  assign rd_ofs    = rd_pos_q - RESET_POS;
  assign rd_byte   = rd_hit_q ? rd_data_q : rd_dflt_q;
  assign put_byte  = copy_q ? rd_byte : cur_q;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign put_last  = !copy_q || (cnt_q == CNT_W'(1));
  assign flag_next = {1'b0, flag_q[15:1]};

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    flag_d      = flag_q;
    mlow_d      = mlow_q;
    cur_d       = cur_q;
    copy_d      = copy_q;
    wp_d        = wp_q;
    rd_pos_d    = rd_pos_q;
    cnt_d       = cnt_q;
    fill_d      = fill_q;
    rd_hit_d    = rd_hit_q;
    rd_dflt_d   = rd_dflt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (phase_q)
            PH_TOKEN: begin
              if (flag_q[0]) begin
                cur_d   = in_byte_i;
                copy_d  = 1'b0;
                state_d = ST_PUT;
              end else begin
                mlow_d  = in_byte_i;
                phase_d = PH_MHIGH;
              end
            end
            PH_MHIGH: begin
              rd_pos_d = {in_byte_i[7:4], mlow_q};
              cnt_d    = CNT_W'(in_byte_i[3:0]) + CNT_W'(MATCH_BIAS + 1);
              copy_d   = 1'b1;
              state_d  = ST_READ;
            end
            default: begin
              // flag byte; upper ones count the tokens still to come
              flag_d  = {8'hff, in_byte_i};
              phase_d = PH_TOKEN;
            end
          endcase
        end
      end
      ST_READ: begin
        mem_re    = 1'b1;
        rd_hit_d  = ({1'b0, rd_ofs} < fill_q);
        rd_dflt_d = (rd_pos_q < RESET_POS) ? SPACE_CHAR : ZERO_CHAR;
        state_d   = ST_PUT;
      end
      ST_PUT: begin
        if (slot_free) begin
          mem_we      = 1'b1;
          wp_d        = wp_q + RING_AW'(1);
          if (fill_q != FILL_W'(RING_DEPTH)) begin
            fill_d = fill_q + FILL_W'(1);
          end
          out_valid_d = 1'b1;
          out_byte_d  = put_byte;
          out_last_d  = put_last;
          if (put_last) begin
            flag_d  = flag_next;
            phase_d = flag_next[8] ? PH_TOKEN : PH_FLAG;
            state_d = ST_IDLE;
          end else begin
            rd_pos_d = rd_pos_q + RING_AW'(1);
            cnt_d    = cnt_q - CNT_W'(1);
            state_d  = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_FLAG;
      flag_q      <= '0;
      mlow_q      <= '0;
      cur_q       <= '0;
      copy_q      <= 1'b0;
      wp_q        <= RESET_POS;
      rd_pos_q    <= '0;
      cnt_q       <= '0;
      fill_q      <= '0;
      rd_hit_q    <= 1'b0;
      rd_dflt_q   <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      flag_q      <= flag_d;
      mlow_q      <= mlow_d;
      cur_q       <= cur_d;
      copy_q      <= copy_d;
      wp_q        <= wp_d;
      rd_pos_q    <= rd_pos_d;
      cnt_q       <= cnt_d;
      fill_q      <= fill_d;
      rd_hit_q    <= rd_hit_d;
      rd_dflt_q   <= rd_dflt_d;
      out_valid_q <= out_valid_d;
      out_byte_q  <= out_byte_d;
      out_last_q  <= out_last_d;
    end
  end

  // history ring: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[wp_q] <= put_byte;
    end
    if (mem_re) begin
      rd_data_q <= ring_mem[rd_pos_q];
    end
  end

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(RING_DEPTH))
    else $error("fill count beyond ring depth");

  a_read_in_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (copy_q && (cnt_q != '0)))
    else $error("ring read outside a match copy");

  a_write_outputs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> (out_valid_o && (out_byte_o == $past(put_byte))))
    else $error("ring write without matching output byte");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && put_last) |=> (state_q == ST_IDLE))
    else $error("sequencer busy after final byte");

endmodule

// ===== sim/lzrd_stream_checker.sv =====
// lzrd_stream_checker: watches both channels of the lzss ring decoder and
// decodes every accepted input byte itself, then compares each output transaction
// depends on lzrd_pkg for ring size, match bias, reset position and phase_e
`timescale 1ns / 1ps

module lzrd_stream_checker
  import lzrd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] in_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_byte_i,
  input  logic       out_last_i,
  output int         fail_cnt_o,
  output int         pending_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } dec_byte_t;

  dec_byte_t          decoded_q[$];
  logic [7:0]         history[RING_DEPTH];
  logic [RING_AW-1:0] wr_pos;
  logic [15:0]        flags;
  phase_e             phase;
  logic [7:0]         pos_low;
  int                 fails = 0;

  assign fail_cnt_o = fails;

  task automatic clear_history();
    for (int i = 0; i < RING_DEPTH; i++) begin
      history[i] = (i < int'(RESET_POS)) ? SPACE_CHAR : ZERO_CHAR;
    end
    wr_pos  = RESET_POS;
    flags   = '0;
    phase   = PH_FLAG;
    pos_low = '0;
  endtask

  task automatic put_byte(input logic [7:0] b, input logic last);
    history[wr_pos] = b;
    wr_pos          = wr_pos + RING_AW'(1);
    decoded_q.push_back('{data: b, last: last});
  endtask

  // one flag used up; the ones above bit 7 count the tokens left
  task automatic next_token();
    flags = flags >> 1;
    phase = flags[8] ? PH_TOKEN : PH_FLAG;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [RING_AW-1:0] src;
    int                 len;
    case (phase)
      PH_TOKEN: begin
        if (flags[0]) begin
          put_byte(b, 1'b1);
          next_token();
        end else begin
          pos_low = b;
          phase   = PH_MHIGH;
        end
      end
      PH_MHIGH: begin
        src = {b[7:4], pos_low};
        len = int'(b[3:0]) + MATCH_BIAS + 1;
        // sequential copy, so an overlapping source repeats fresh bytes
        for (int k = 0; k < len; k++) begin
          put_byte(history[src], k == len - 1);
          src = src + RING_AW'(1);
        end
        next_token();
      end
      default: begin
        flags = {8'hff, b};
        phase = PH_TOKEN;
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    dec_byte_t exp_b;
    if (!rst_ni) begin
      clear_history();
      decoded_q.delete();
      pending_o <= 0;
    end else begin
      // outputs first: a result never belongs to the input taken at the same edge
      if (out_valid_i && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          fails++;
          if (fails < 40) begin
            $display("%0t: unexpected output: expected none, got byte %h last %b",
                     $time, out_byte_i, out_last_i);
          end
        end else begin
          exp_b = decoded_q.pop_front();
          if (exp_b.data !== out_byte_i || exp_b.last !== out_last_i) begin
            fails++;
            if (fails < 40) begin
              $display("%0t: mismatch: expected byte %h last %b, got byte %h last %b",
                       $time, exp_b.data, exp_b.last, out_byte_i, out_last_i);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        decode_byte(in_byte_i);
      end
      pending_o <= decoded_q.size();
    end
  end

endmodule

// ===== sim/lzss_ring_decoder_tb.sv =====
// lzss_ring_decoder_tb: drives compressed streams into the lzss ring decoder
// with random gaps and output stalls; depends on lzrd_pkg, lzrd_stream_checker and lzss_ring_decoder
`timescale 1ns / 1ps

module lzss_ring_decoder_tb
  import lzrd_pkg::*;
();

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = '0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  int         fail_cnt;
  int         pending;

  int                 sent      = 0;
  int                 idle_pct  = 0;
  int                 stall_pct = 0;
  int                 pause_at  = 15;
  logic [RING_AW-1:0] wr_guess  = RESET_POS;

  always #5 clk = ~clk;

  lzss_ring_decoder DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_byte_i  (in_byte),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_byte_o (out_byte),
    .out_last_o (out_last)
  );

  lzrd_stream_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_byte_i  (in_byte),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_byte_i (out_byte),
    .out_last_i (out_last),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // hold the input low until the decoder has delivered everything
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_literal(input logic [7:0] b);
    send_byte(b);
    wr_guess = wr_guess + RING_AW'(1);
  endtask

  task automatic send_match(input logic [RING_AW-1:0] src, input logic [3:0] len_code);
    send_byte(src[7:0]);
    // now and then the stream stops in the middle of a match
    if (sent >= pause_at) begin
      drain();
      pause_at += 120;
    end
    send_byte({src[11:8], len_code});
    wr_guess = RING_AW'(int'(wr_guess) + int'(len_code) + MATCH_BIAS + 1);
  endtask

  task automatic set_mode(input int m);
    case (m)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 52; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 52; end
      default: begin idle_pct = 23; stall_pct = 23; end
    endcase
  endtask

  task automatic send_group();
    logic [7:0]         fl;
    logic [RING_AW-1:0] src;
    int                 r;
    r  = $urandom_range(99);
    fl = (r < 20) ? 8'h00 : (r < 35) ? 8'hff : 8'($urandom);
    send_byte(fl);
    for (int i = 0; i < 8; i++) begin
      if (fl[i]) begin
        send_literal(8'($urandom));
      end else begin
        r = $urandom_range(99);
        // mostly short back references, often overlapping the copy itself
        if (r < 60) src = wr_guess - RING_AW'($urandom_range(1, 24));
        else        src = RING_AW'($urandom);
        send_match(src, 4'($urandom_range(0, 15)));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    set_mode(0);

    // eight literals with the byte extremes
    send_byte(8'hff);
    send_literal(8'h00);
    send_literal(8'hff);
    send_literal(8'h55);
    send_literal(8'haa);
    send_literal(8'h41);
    send_literal(8'h42);
    send_literal(8'h43);
    send_literal(8'h7e);
    // four matches then four literals
    send_byte(8'hf0);
    send_match(12'hfff, 4'h0);              // unwritten top entry, wraps to spaces
    send_match(12'h000, 4'hf);              // longest copy, writes wrap around
    send_match(wr_guess - RING_AW'(1), 4'hf);  // overlap repeats one byte
    send_match(RESET_POS, 4'h5);            // read back the first literals
    send_literal(8'h80);
    send_literal(8'h01);
    send_literal(8'h7f);
    send_literal(8'hfe);

    while (sent < 270) begin
      set_mode((sent / 50) % 4);
      send_group();
    end

    drain();
    repeat (60) @(posedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
